// File: design/cltr_pkg.sv
// ----------------------------------------------------------------------------
// cltr_pkg
// Shared types, constants and letter tables for the Cyrillic to Latin
// transliterator.
// ----------------------------------------------------------------------------
`default_nettype none

package cltr_pkg;

	localparam int CP_W    = 21;   // code point width
	localparam int TDATA_W = 24;   // code point padded to whole bytes
	localparam int LAT_W   = 10;   // widest Latin output in the table is U+0292
	localparam int MAX_RES = 4;    // results one item can cause
	localparam int CNT_W   = 3;    // holds 0..MAX_RES
	localparam int IDX_W   = 2;    // indexes 0..MAX_RES-1

	localparam logic [CP_W-1:0] APOSTROPHE = 21'h00027;
	localparam logic [CP_W-1:0] SOFT_SIGN  = 21'h0044C;
	localparam logic [CP_W-1:0] CARON      = 21'h0030C;

	typedef enum logic [1:0] {
		CLS_CONS  = 2'd0,
		CLS_VOWEL = 2'd1,
		CLS_IOT   = 2'd2
	} cls_t;

	typedef struct packed {
		logic             found;
		cls_t             cls;
		logic [LAT_W-1:0] first;
		logic [LAT_W-1:0] second;
	} letter_t;

	// everything the translation stage hands to the result buffer
	typedef struct packed {
		logic [CNT_W-1:0]               count;
		logic [MAX_RES-1:0][CP_W-1:0]   cps;
		logic                           next_valid;
		logic [CP_W-1:0]                next_letter;
	} xlat_res_t;

	function automatic logic [CP_W-1:0] to_lower(input logic [CP_W-1:0] c);
		logic [CP_W-1:0] r;
		r = c;
		if (c >= 21'h00410 && c <= 21'h0042F)
			r = c + 21'h00020;
		else if (c >= 21'h00400 && c <= 21'h0040F)
			r = c + 21'h00050;
		else if (c == 21'h00490)
			r = 21'h00491;
		return r;
	endfunction

	function automatic logic [LAT_W-1:0] latin_upper(input logic [LAT_W-1:0] c);
		logic [LAT_W-1:0] r;
		r = c;
		if (c >= 10'h061 && c <= 10'h07A)
			r = c - 10'h020;
		else if (c == 10'h15B)
			r = 10'h15A;
		else if (c == 10'h107)
			r = 10'h106;
		else if (c == 10'h292)
			r = 10'h1B7;
		return r;
	endfunction

	function automatic letter_t mk(input cls_t cls, input logic [LAT_W-1:0] a,
			input logic [LAT_W-1:0] b);
		letter_t r;
		r.found  = 1'b1;
		r.cls    = cls;
		r.first  = a;
		r.second = b;
		return r;
	endfunction

	// lookup on a lowercase code point
	function automatic letter_t letter_info(input logic [CP_W-1:0] lc);
		letter_t r;
		r = '0;
		case (lc)
			21'h00439: r = mk(CLS_CONS, 10'h06A, 10'h000);
			21'h00446: r = mk(CLS_CONS, 10'h063, 10'h000);
			21'h0043A: r = mk(CLS_CONS, 10'h06B, 10'h000);
			21'h0043D: r = mk(CLS_CONS, 10'h06E, 10'h000);
			21'h00433: r = mk(CLS_CONS, 10'h068, 10'h000);
			21'h00448: r = mk(CLS_CONS, 10'h15B, 10'h000);
			21'h00449: r = mk(CLS_CONS, 10'h15B, 10'h107);
			21'h00437: r = mk(CLS_CONS, 10'h07A, 10'h000);
			21'h00445: r = mk(CLS_CONS, 10'h078, 10'h000);
			21'h00444: r = mk(CLS_CONS, 10'h066, 10'h000);
			21'h00432: r = mk(CLS_CONS, 10'h076, 10'h000);
			21'h0043F: r = mk(CLS_CONS, 10'h070, 10'h000);
			21'h00440: r = mk(CLS_CONS, 10'h072, 10'h000);
			21'h0043B: r = mk(CLS_CONS, 10'h06C, 10'h000);
			21'h00434: r = mk(CLS_CONS, 10'h064, 10'h000);
			21'h00436: r = mk(CLS_CONS, 10'h292, 10'h000);
			21'h00447: r = mk(CLS_CONS, 10'h107, 10'h000);
			21'h00441: r = mk(CLS_CONS, 10'h073, 10'h000);
			21'h0043C: r = mk(CLS_CONS, 10'h06D, 10'h000);
			21'h00442: r = mk(CLS_CONS, 10'h074, 10'h000);
			21'h0044C: r = mk(CLS_CONS, 10'h000, 10'h000);
			21'h00431: r = mk(CLS_CONS, 10'h062, 10'h000);
			21'h00491: r = mk(CLS_CONS, 10'h067, 10'h000);
			21'h00456: r = mk(CLS_VOWEL, 10'h069, 10'h000);
			21'h00435: r = mk(CLS_VOWEL, 10'h065, 10'h000);
			21'h00430: r = mk(CLS_VOWEL, 10'h061, 10'h000);
			21'h00443: r = mk(CLS_VOWEL, 10'h075, 10'h000);
			21'h0043E: r = mk(CLS_VOWEL, 10'h06F, 10'h000);
			21'h00438: r = mk(CLS_VOWEL, 10'h079, 10'h000);
			21'h00457: r = mk(CLS_IOT, 10'h06A, 10'h069);
			21'h00454: r = mk(CLS_IOT, 10'h06A, 10'h065);
			21'h0044F: r = mk(CLS_IOT, 10'h06A, 10'h061);
			21'h0044E: r = mk(CLS_IOT, 10'h06A, 10'h075);
			default:   r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/cltr_xlat.sv
// ----------------------------------------------------------------------------
// cltr_xlat
// Combinational translation of one item against the pending letter: builds
// the list of output code points and the next pending state.
// ----------------------------------------------------------------------------
`default_nettype none

module cltr_xlat (
	input  wire logic                     kind,
	input  wire logic [cltr_pkg::CP_W-1:0] code_point,
	input  wire logic                     pend_valid,
	input  wire logic [cltr_pkg::CP_W-1:0] pend_letter,
	output cltr_pkg::xlat_res_t           res
);
	import cltr_pkg::*;

	logic [CP_W-1:0]  p_lower;
	logic [CP_W-1:0]  c_lower;
	letter_t          pi;
	letter_t          ci;
	logic             p_up;
	logic             c_up;
	logic             tr_has;
	logic             tr_has2;
	logic [LAT_W-1:0] tr_a;
	logic             c_is_letter;
	logic             pair;
	logic [LAT_W-1:0] vowel;
	logic [CNT_W-1:0] n;

	always_comb begin
		p_lower = to_lower(pend_letter);
		c_lower = to_lower(code_point);
		pi      = letter_info(p_lower);
		ci      = letter_info(c_lower);
		p_up    = (p_lower != pend_letter);
		c_up    = (c_lower != code_point);

		// translation of the pending letter; soft sign and apostrophe give nothing
		tr_has  = pend_valid && pi.found && (pi.first != '0);
		tr_has2 = tr_has && (pi.second != '0);
		tr_a    = p_up ? latin_upper(pi.first) : pi.first;

		c_is_letter = (code_point == APOSTROPHE) || ci.found;
		pair = (code_point == APOSTROPHE) || (code_point == SOFT_SIGN) ||
			(ci.found && ci.cls == CLS_IOT && pi.found && pi.cls == CLS_CONS);
		vowel = c_up ? latin_upper(ci.second) : ci.second;

		n               = '0;
		res.cps         = '0;
		res.next_valid  = 1'b0;
		res.next_letter = '0;

		if (!kind && c_is_letter && !pend_valid) begin
			// first letter of a run is only held
			res.next_valid  = 1'b1;
			res.next_letter = code_point;
		end else begin
			if (tr_has) begin
				res.cps[n[IDX_W-1:0]] = CP_W'(tr_a);
				n = n + 3'd1;
			end
			if (tr_has2) begin
				res.cps[n[IDX_W-1:0]] = CP_W'(pi.second);
				n = n + 3'd1;
			end
			if (!kind) begin
				if (!c_is_letter) begin
					res.cps[n[IDX_W-1:0]] = code_point;
					n = n + 3'd1;
				end else if (pair) begin
					if (code_point != APOSTROPHE) begin
						res.cps[n[IDX_W-1:0]] = CARON;
						n = n + 3'd1;
					end
					if (ci.found && ci.cls == CLS_IOT) begin
						res.cps[n[IDX_W-1:0]] = CP_W'(vowel);
						n = n + 3'd1;
					end
				end else begin
					res.next_valid  = 1'b1;
					res.next_letter = code_point;
				end
			end
		end
		res.count = n;
	end

endmodule

`default_nettype wire

// File: design/cyrillic_to_latin_transliterator_unit.sv
// ----------------------------------------------------------------------------
// cyrillic_to_latin_transliterator_unit
// Ukrainian Cyrillic to Latin transliteration of a code point stream.
// ----------------------------------------------------------------------------
// Each beat in is latched, translated against the one pending letter and the resulting
// zero to four code points are loaded into a four-entry result shift register that
// drains one beat per cycle while m_tready is high. An item that gives at most one
// result leaves room for the next in the following cycle, so the block takes one item
// per cycle on such text while the receiver is ready; an item that gives more results
// holds the output side until they drain, which is what bounds the rate. An item passes
// from the input register into the result shift register before its first result shows.
// Letters are held until the next item, so end-of-text (tuser set) flushes the last one.
`default_nettype none

module cyrillic_to_latin_transliterator_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [cltr_pkg::TDATA_W-1:0] s_tdata,  // [20:0] code_point, [23:21] zero
	input  wire logic                         s_tuser,  // [0] kind: end of text
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [cltr_pkg::TDATA_W-1:0]      m_tdata,  // [20:0] out_code_point, [23:21] zero
	output logic                              m_tlast
);
	import cltr_pkg::*;

	logic                          valid_s1;
	logic                          kind_s1;
	logic [CP_W-1:0]               cp_s1;
	logic                          pend_valid_q;
	logic [CP_W-1:0]               pend_letter_q;
	logic [MAX_RES-1:0][CP_W-1:0]  res_cp_q;
	logic [CNT_W-1:0]              res_cnt_q;
	xlat_res_t                     xres;
	logic                          pop;
	logic                          load;

	cltr_xlat u_xlat (
		.kind        (kind_s1),
		.code_point  (cp_s1),
		.pend_valid  (pend_valid_q),
		.pend_letter (pend_letter_q),
		.res         (xres)
	);

	assign m_tvalid = (res_cnt_q != '0);
	assign pop      = m_tvalid && m_tready;
	// buffer free now or after its final beat goes this cycle
	assign load     = valid_s1 && ((res_cnt_q == '0) || (res_cnt_q == 3'd1 && m_tready));
	assign s_tready = !valid_s1 || load;
	assign m_tdata  = TDATA_W'(res_cp_q[0]);
	assign m_tlast  = (res_cnt_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			cp_s1   <= s_tdata[CP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q  <= 1'b0;
			pend_letter_q <= '0;
			res_cnt_q     <= '0;
		end else if (load) begin
			pend_valid_q  <= xres.next_valid;
			pend_letter_q <= xres.next_letter;
			res_cnt_q     <= xres.count;
		end else if (pop) begin
			res_cnt_q <= res_cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_cp_q <= xres.cps;
		end else if (pop) begin
			res_cp_q <= {CP_W'(0), res_cp_q[MAX_RES-1:1]};
		end
	end

endmodule

`default_nettype wire

// File: design/cltr_checker.sv
// ----------------------------------------------------------------------------
// cltr_checker
// Port-level checks on the transliterator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cltr_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         s_tready,
	input wire logic                         m_tvalid,
	input wire logic                         m_tready,
	input wire logic [cltr_pkg::TDATA_W-1:0] m_tdata,
	input wire logic                         m_tlast
);
	import cltr_pkg::*;

	// a stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output beat changed");

	// input is only back-pressured while results are waiting
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with output idle");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[TDATA_W-1:CP_W] == '0)
		else $error("output padding bits not zero");

	// a caron that is not last comes from an iotated vowel: the plain vowel follows
	a_iot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast && m_tdata[CP_W-1:0] == CARON |=>
		m_tvalid && (m_tdata[CP_W-1:0] == 21'h69 || m_tdata[CP_W-1:0] == 21'h65 ||
			m_tdata[CP_W-1:0] == 21'h61 || m_tdata[CP_W-1:0] == 21'h75 ||
			m_tdata[CP_W-1:0] == 21'h49 || m_tdata[CP_W-1:0] == 21'h45 ||
			m_tdata[CP_W-1:0] == 21'h41 || m_tdata[CP_W-1:0] == 21'h55))
		else $error("caron not followed by plain vowel");

endmodule

bind cyrillic_to_latin_transliterator_unit cltr_checker u_cltr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Cyrillic to Latin transliterator unit.
// ----------------------------------------------------------------------------
// A short directed text covers pairing with the apostrophe and the soft sign,
// consonant plus iotated vowel in both cases, capitalised multi-letter output
// and end-of-text flushes. Random text follows: mostly Ukrainian letters with
// some noise and end markers. Each accepted beat in updates a scoreboard that
// tracks the held letter and queues the expected characters. Each beat out is
// compared with the oldest expected one. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cltr_pkg::*;

	localparam int RANDOM_ITEMS = 230;
	localparam int CALM_ITEMS   = 40;    // final stretch with no idling
	localparam int HOLD_CYCLES  = 120;   // long receiver hold-off
	localparam int HOLD_AFTER   = 60;    // items taken before the hold-off
	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 8;

	class xlit_scoreboard;
		typedef struct packed {
			logic [CP_W-1:0] cp;
			logic            last;
		} char_beat_t;

		char_beat_t      expected_q[$];
		char_beat_t      fresh_q[$];
		logic [CP_W-1:0] held_cp;
		bit              held;
		int              failures;
		int              reported;

		function new();
			held_cp  = '0;
			held     = 1'b0;
			failures = 0;
			reported = 0;
		endfunction

		function int waiting();
			return expected_q.size();
		endfunction

		function logic [CP_W-1:0] fold_case(input logic [CP_W-1:0] c);
			if (c >= 21'h410 && c <= 21'h42F)
				return c + 21'h20;
			if (c >= 21'h400 && c <= 21'h40F)
				return c + 21'h50;
			if (c == 21'h490)
				return 21'h491;
			return c;
		endfunction

		function logic [CP_W-1:0] capital(input logic [CP_W-1:0] c);
			if (c >= 21'h61 && c <= 21'h7A)
				return c - 21'h20;
			if (c == 21'h15B)
				return 21'h15A;
			if (c == 21'h107)
				return 21'h106;
			if (c == 21'h292)
				return 21'h1B7;
			return c;
		endfunction

		// table of lowercase letters: class and up to two latin characters
		function bit lookup(input logic [CP_W-1:0] lc, output cls_t cls,
				output logic [CP_W-1:0] a, output logic [CP_W-1:0] b);
			bit found;
			found = 1'b1;
			cls   = CLS_CONS;
			a     = '0;
			b     = '0;
			case (lc)
				21'h439: a = 21'h06A;
				21'h446: a = 21'h063;
				21'h43A: a = 21'h06B;
				21'h43D: a = 21'h06E;
				21'h433: a = 21'h068;
				21'h448: a = 21'h15B;
				21'h449: begin
					a = 21'h15B;
					b = 21'h107;
				end
				21'h437: a = 21'h07A;
				21'h445: a = 21'h078;
				21'h444: a = 21'h066;
				21'h432: a = 21'h076;
				21'h43F: a = 21'h070;
				21'h440: a = 21'h072;
				21'h43B: a = 21'h06C;
				21'h434: a = 21'h064;
				21'h436: a = 21'h292;
				21'h447: a = 21'h107;
				21'h441: a = 21'h073;
				21'h43C: a = 21'h06D;
				21'h442: a = 21'h074;
				21'h44C: a = '0;
				21'h431: a = 21'h062;
				21'h491: a = 21'h067;
				21'h456: begin
					cls = CLS_VOWEL;
					a = 21'h069;
				end
				21'h435: begin
					cls = CLS_VOWEL;
					a = 21'h065;
				end
				21'h430: begin
					cls = CLS_VOWEL;
					a = 21'h061;
				end
				21'h443: begin
					cls = CLS_VOWEL;
					a = 21'h075;
				end
				21'h43E: begin
					cls = CLS_VOWEL;
					a = 21'h06F;
				end
				21'h438: begin
					cls = CLS_VOWEL;
					a = 21'h079;
				end
				21'h457: begin
					cls = CLS_IOT;
					a = 21'h06A;
					b = 21'h069;
				end
				21'h454: begin
					cls = CLS_IOT;
					a = 21'h06A;
					b = 21'h065;
				end
				21'h44F: begin
					cls = CLS_IOT;
					a = 21'h06A;
					b = 21'h061;
				end
				21'h44E: begin
					cls = CLS_IOT;
					a = 21'h06A;
					b = 21'h075;
				end
				default: found = 1'b0;
			endcase
			return found;
		endfunction

		function void emit(input logic [CP_W-1:0] cp);
			char_beat_t nb;
			nb.cp   = cp;
			nb.last = 1'b0;
			fresh_q.push_back(nb);
		endfunction

		function void spell(input logic [CP_W-1:0] c);
			cls_t            cls;
			logic [CP_W-1:0] a;
			logic [CP_W-1:0] b;
			bit              found;
			found = lookup(fold_case(c), cls, a, b);
			// soft sign of either case spells nothing
			if (!found || a == '0)
				return;
			emit(fold_case(c) != c ? capital(a) : a);
			if (b != '0)
				emit(b);
		endfunction

		function void spell_pair(input logic [CP_W-1:0] lead, input logic [CP_W-1:0] follow);
			cls_t            cls;
			logic [CP_W-1:0] a;
			logic [CP_W-1:0] b;
			bit              found;
			spell(lead);
			if (follow != APOSTROPHE)
				emit(CARON);
			found = lookup(fold_case(follow), cls, a, b);
			// plain vowel of an iotated follower keeps its case
			if (found && cls == CLS_IOT)
				emit(fold_case(follow) != follow ? capital(b) : b);
		endfunction

		function void note_item(input bit eot, input logic [CP_W-1:0] cp);
			cls_t            c_cls;
			cls_t            h_cls;
			logic [CP_W-1:0] a;
			logic [CP_W-1:0] b;
			bit              c_found;
			bit              h_found;
			fresh_q.delete();
			c_found = lookup(fold_case(cp), c_cls, a, b);
			h_found = lookup(fold_case(held_cp), h_cls, a, b);
			if (eot) begin
				if (held)
					spell(held_cp);
				held    = 1'b0;
				held_cp = '0;
			end else if (!(cp == APOSTROPHE || c_found)) begin
				if (held)
					spell(held_cp);
				held    = 1'b0;
				held_cp = '0;
				emit(cp);
			end else if (!held) begin
				held    = 1'b1;
				held_cp = cp;
			end else if (cp == APOSTROPHE || cp == SOFT_SIGN ||
					(c_found && c_cls == CLS_IOT && h_found && h_cls == CLS_CONS)) begin
				spell_pair(held_cp, cp);
				held    = 1'b0;
				held_cp = '0;
			end else begin
				spell(held_cp);
				held_cp = cp;
			end
			if (fresh_q.size() > 0)
				fresh_q[fresh_q.size()-1].last = 1'b1;
			foreach (fresh_q[i])
				expected_q.push_back(fresh_q[i]);
		endfunction

		function void check_beat(input logic [CP_W-1:0] cp, input logic last);
			char_beat_t want;
			if (expected_q.size() == 0) begin
				failures++;
				if (reported < 10) begin
					reported++;
					$display("unexpected beat: cp %06h last %b", cp, last);
				end
				return;
			end
			want = expected_q.pop_front();
			if (want.cp !== cp || want.last !== last) begin
				failures++;
				if (reported < 10) begin
					reported++;
					$display("mismatch: expected cp %06h last %b, got cp %06h last %b",
						want.cp, want.last, cp, last);
				end
			end
		endfunction
	endclass

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata  = '0;
	logic               s_tuser  = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tlast;

	xlit_scoreboard sb = new();

	bit idle_on   = 1'b1;
	bit hold_done = 1'b0;
	int items_in  = 0;
	int quiet_cycles = 0;

	always #6 clk = ~clk;

	cyrillic_to_latin_transliterator_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	task automatic send_item(input bit eot, input logic [CP_W-1:0] cp);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= eot;
		s_tdata  <= {{(TDATA_W-CP_W){1'b0}}, cp};
		do @(posedge clk); while (!s_tready);
		sb.note_item(eot, cp);
		items_in++;
	endtask

	task automatic send_char(input logic [CP_W-1:0] cp);
		send_item(1'b0, cp);
	endtask

	task automatic send_end();
		send_item(1'b1, CP_W'($urandom_range(0, 21'h10FFFF)));
	endtask

	// mostly Ukrainian letters, some apostrophes and soft signs, some noise
	function automatic logic [CP_W-1:0] pick_char();
		int              r;
		int              k;
		logic [CP_W-1:0] c;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			k = $urandom_range(0, 35);
			case (k)
				32:      c = 21'h454;
				33:      c = 21'h456;
				34:      c = 21'h457;
				35:      c = 21'h491;
				default: c = 21'h430 + CP_W'(k);
			endcase
			if ($urandom_range(0, 3) == 0) begin
				if (c == 21'h491)
					c = 21'h490;
				else if (c >= 21'h450)
					c = c - 21'h50;
				else
					c = c - 21'h20;
			end
		end else if (r < 60)
			c = SOFT_SIGN;
		else if (r < 68)
			c = APOSTROPHE;
		else if (r < 74)
			c = CP_W'($urandom_range(21'h400, 21'h4FF));
		else if (r < 90)
			c = CP_W'($urandom_range(21'h20, 21'h7E));
		else
			c = CP_W'($urandom_range(0, 21'h10FFFF));
		return c;
	endfunction

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_beat(m_tdata[CP_W-1:0], m_tlast);
	end

	// receiver: random stalls plus one long hold-off to back up the input
	initial begin
		forever begin
			@(posedge clk);
			if (!hold_done && items_in >= HOLD_AFTER) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// four characters from one beat, capital first letter only
		send_char(21'h429);
		send_char(21'h44E);
		// uppercase consonant and iotated vowel
		send_char(21'h41B);
		send_char(21'h42F);
		// apostrophe and lowercase soft sign as followers
		send_char(21'h431);
		send_char(APOSTROPHE);
		send_char(21'h442);
		send_char(SOFT_SIGN);
		// uppercase soft sign is held, then flushes to nothing
		send_char(21'h422);
		send_char(21'h42C);
		send_end();
		// a held apostrophe still pairs with a following soft sign, which gives the caron
		send_char(APOSTROPHE);
		send_char(SOFT_SIGN);
		send_char(SOFT_SIGN);
		send_char(21'h20);
		// capital ezh, c acute, g with a following capital yi
		send_char(21'h416);
		send_char(21'h427);
		send_char(21'h490);
		send_char(21'h407);
		// vowel then iotated vowel, flushed by the top code point
		send_char(21'h430);
		send_char(21'h44F);
		send_char(21'h10FFFF);
		send_char(21'h000000);
		send_end();
		send_char(21'h404);
		send_end();

		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.waiting() != 0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			idle_on = (i < RANDOM_ITEMS - CALM_ITEMS) && ((i / 30) % 3 != 2);
			if ($urandom_range(0, 24) == 0)
				send_end();
			else
				send_char(pick_char());
		end
		send_end();
		s_tvalid <= 1'b0;

		while (sb.waiting() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.waiting() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

// File: cyrillic_to_latin_transliterator_unit.f
design/cltr_pkg.sv
design/cltr_xlat.sv
design/cyrillic_to_latin_transliterator_unit.sv
design/cltr_checker.sv
verif/tb.sv
